FILE: rtl/tksd_pkg.sv
`default_nettype none
package tksd_pkg;

   // parser modes
   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_ESC,
      MODE_CSI,
      MODE_CSI_NUM1,
      MODE_CSI_NUM2,
      MODE_SS3,
      MODE_MOUSE,
      MODE_MOUSE_END
   } mode_type;

   localparam int KEY_W   = 13;
   localparam int ACC_W   = 12;
   localparam int BTN_W   = 8;
   localparam int NUM_ACC = 3;
   localparam int IDX_W   = 2;

   localparam logic [KEY_W-1:0] KEY_ESCAPE  = 13'd27;
   localparam logic [KEY_W-1:0] KEY_MOUSE   = 13'd7001;
   localparam logic [KEY_W-1:0] KEY_CTRL    = 13'd3000;
   localparam logic [KEY_W-1:0] KEY_UP      = 13'd1001;
   localparam logic [KEY_W-1:0] KEY_DOWN    = 13'd1002;
   localparam logic [KEY_W-1:0] KEY_RIGHT   = 13'd1003;
   localparam logic [KEY_W-1:0] KEY_LEFT    = 13'd1004;
   localparam logic [KEY_W-1:0] KEY_HOME    = 13'd1005;
   localparam logic [KEY_W-1:0] KEY_END     = 13'd1006;
   localparam logic [KEY_W-1:0] KEY_PGUP    = 13'd1007;
   localparam logic [KEY_W-1:0] KEY_PGDN    = 13'd1008;
   localparam logic [KEY_W-1:0] KEY_DELETE  = 13'd1009;
   localparam logic [KEY_W-1:0] KEY_F1      = 13'd2001;
   localparam logic [KEY_W-1:0] KEY_BACKTAB = 13'd5001;
   localparam logic [KEY_W-1:0] KEY_NONE    = 13'd0;

   localparam logic [ACC_W-1:0] ACC_MAX = 12'd4095;
   localparam logic [BTN_W-1:0] BTN_MAX = 8'd255;

   localparam logic [7:0] CH_ESC   = 8'd27;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_LBRK  = 8'h5B;  // [
   localparam logic [7:0] CH_SS3   = 8'h4F;  // O
   localparam logic [7:0] CH_LT    = 8'h3C;  // <
   localparam logic [7:0] CH_SEMI  = 8'h3B;  // ;
   localparam logic [7:0] CH_TILDE = 8'h7E;  // ~
   localparam logic [7:0] CH_PRESS = 8'h4D;  // M
   localparam logic [7:0] CH_REL   = 8'h6D;  // m
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_B     = 8'h42;
   localparam logic [7:0] CH_C     = 8'h43;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_H     = 8'h48;
   localparam logic [7:0] CH_F     = 8'h46;
   localparam logic [7:0] CH_Z     = 8'h5A;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;

   // two-digit tilde numbers 11..24 to function keys, KEY_NONE if unused
   function automatic logic [KEY_W-1:0] fkey_lookup(input logic [6:0] code);
      logic [KEY_W-1:0] k;
      case (code)
         7'd11:   k = 13'd2001;
         7'd12:   k = 13'd2002;
         7'd13:   k = 13'd2003;
         7'd14:   k = 13'd2004;
         7'd15:   k = 13'd2005;
         7'd17:   k = 13'd2006;
         7'd18:   k = 13'd2007;
         7'd19:   k = 13'd2008;
         7'd20:   k = 13'd2009;
         7'd21:   k = 13'd2010;
         7'd23:   k = 13'd2011;
         7'd24:   k = 13'd2012;
         default: k = KEY_NONE;
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/terminal_key_sequence_decoder.sv
`default_nettype none
// Terminal key sequence decoder.
// Input channel (req_*): one terminal event per item, either a received byte
// (req_timed_out = 0, byte on req_rx_byte) or a read timeout (req_timed_out = 1).
// Result channel (rsp_*): at most one decoded key per item on rsp_key_code,
// together with the stored SGR mouse report (button, column, row, pressed)
// as it stands after that item.
// Latency: the result of an item is valid in the cycle after it is accepted.
// Items that only advance an escape sequence, and timeouts while idle,
// produce no result.
// Throughput: one item per cycle. The parser state and the output register
// update at the same edge; req_ready is high whenever the output register is
// empty or is being drained in that cycle.
// Stall: while a result waits with rsp_ready low, req_ready drops and the
// parser state holds, so the mouse fields of the waiting item stay stable.
// Reset: synchronous, active high; parser returns to idle, accumulators and
// the stored mouse report clear, no result is pending.
module terminal_key_sequence_decoder
   import tksd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic             req_timed_out,
   input  wire logic [7:0]       req_rx_byte,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [KEY_W-1:0]      rsp_key_code,
   output logic [BTN_W-1:0]      rsp_mouse_button_out,
   output logic [ACC_W-1:0]      rsp_mouse_column_out,
   output logic [ACC_W-1:0]      rsp_mouse_row_out,
   output logic                  rsp_mouse_pressed_out
);

   // parser state
   mode_type         mode_ff, mode_in;
   logic [3:0]       first_ff, first_in;
   logic [ACC_W-1:0] acc_ff [NUM_ACC];
   logic [ACC_W-1:0] acc_in [NUM_ACC];
   logic [IDX_W-1:0] idx_ff, idx_in;

   // stored mouse report
   logic [BTN_W-1:0] btn_ff, btn_in;
   logic [ACC_W-1:0] col_ff, col_in;
   logic [ACC_W-1:0] row_ff, row_in;
   logic             press_ff, press_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0] key_ff;

   logic             req_fire;
   logic             emit;
   logic             finish;
   logic [KEY_W-1:0] key;
   logic             digit;
   logic [3:0]       dval;
   logic [IDX_W-1:0] mi;
   logic [15:0]      acc_x10;
   logic [6:0]       two_digit;
   logic [KEY_W-1:0] fkey;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      mode_in   = mode_ff;
      first_in  = first_ff;
      acc_in    = acc_ff;
      idx_in    = idx_ff;
      btn_in    = btn_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      press_in  = press_ff;
      emit      = 1'b0;
      finish    = 1'b0;
      key       = KEY_ESCAPE;

      digit     = !req_timed_out && (req_rx_byte inside {[CH_0:CH_9]});
      dval      = req_rx_byte[3:0];
      // index past the last number sticks at the last one
      mi        = (idx_ff == 2'd3) ? 2'd2 : idx_ff;
      acc_x10   = {1'b0, acc_ff[mi], 3'b000} + {3'b000, acc_ff[mi], 1'b0}
                  + {12'd0, dval};
      two_digit = 7'({first_ff, 3'b000} + {2'b00, first_ff, 1'b0})
                  + {3'd0, dval};
      fkey      = fkey_lookup(acc_ff[0][6:0]);

      case (mode_ff)
         MODE_IDLE: begin
            if (!req_timed_out) begin
               if ((req_rx_byte inside {[8'd1:8'd26]}) && req_rx_byte != CH_TAB
                   && req_rx_byte != CH_LF && req_rx_byte != CH_CR) begin
                  emit = 1'b1;
                  key  = KEY_CTRL + {5'd0, req_rx_byte};
               end else if (req_rx_byte != CH_ESC) begin
                  emit = 1'b1;
                  key  = {5'd0, req_rx_byte};
               end else begin
                  mode_in = MODE_ESC;
               end
            end
         end
         MODE_ESC: begin
            if (!req_timed_out && req_rx_byte == CH_LBRK) begin
               mode_in = MODE_CSI;
            end else if (!req_timed_out && req_rx_byte == CH_SS3) begin
               mode_in = MODE_SS3;
            end else begin
               emit = 1'b1;
            end
         end
         MODE_CSI: begin
            if (req_timed_out) begin
               emit = 1'b1;
            end else begin
               case (req_rx_byte)
                  CH_A: begin emit = 1'b1; key = KEY_UP;      end
                  CH_B: begin emit = 1'b1; key = KEY_DOWN;    end
                  CH_C: begin emit = 1'b1; key = KEY_RIGHT;   end
                  CH_D: begin emit = 1'b1; key = KEY_LEFT;    end
                  CH_H: begin emit = 1'b1; key = KEY_HOME;    end
                  CH_F: begin emit = 1'b1; key = KEY_END;     end
                  CH_Z: begin emit = 1'b1; key = KEY_BACKTAB; end
                  CH_LT: begin
                     for (int k = 0; k < NUM_ACC; k++) acc_in[k] = '0;
                     idx_in  = '0;
                     mode_in = MODE_MOUSE;
                  end
                  default: begin
                     if (digit) begin
                        first_in = dval;
                        mode_in  = MODE_CSI_NUM1;
                     end else begin
                        emit = 1'b1;
                     end
                  end
               endcase
            end
         end
         MODE_CSI_NUM1: begin
            if (!req_timed_out && req_rx_byte == CH_TILDE) begin
               emit = 1'b1;
               case (first_ff)
                  4'd3:    key = KEY_DELETE;
                  4'd5:    key = KEY_PGUP;
                  4'd6:    key = KEY_PGDN;
                  default: key = KEY_ESCAPE;
               endcase
            end else if (digit) begin
               acc_in[0] = {5'd0, two_digit};
               mode_in   = MODE_CSI_NUM2;
            end else begin
               emit = 1'b1;
            end
         end
         MODE_CSI_NUM2: begin
            emit = 1'b1;
            // accumulator is at most 99 here, so the low bits decide
            if (!req_timed_out && req_rx_byte == CH_TILDE
                && acc_ff[0][ACC_W-1:7] == '0 && fkey != KEY_NONE) begin
               key = fkey;
            end
         end
         MODE_SS3: begin
            emit = 1'b1;
            if (!req_timed_out && (req_rx_byte inside {[CH_P:CH_S]})) begin
               key = KEY_F1 + {11'd0, req_rx_byte[1:0]};
            end
         end
         MODE_MOUSE: begin
            if (digit) begin
               acc_in[mi] = (acc_x10 > {4'd0, ACC_MAX}) ? ACC_MAX : acc_x10[ACC_W-1:0];
            end else if (!req_timed_out && req_rx_byte == CH_SEMI) begin
               if (mi == 2'd2) mode_in = MODE_MOUSE_END;
               else            idx_in  = mi + 2'd1;
            end else if (!req_timed_out && mi == 2'd2
                         && (req_rx_byte == CH_PRESS || req_rx_byte == CH_REL)) begin
               finish = 1'b1;
            end else begin
               emit = 1'b1;
            end
         end
         MODE_MOUSE_END: begin
            if (!req_timed_out
                && (req_rx_byte == CH_PRESS || req_rx_byte == CH_REL)) begin
               finish = 1'b1;
            end else begin
               emit = 1'b1;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase

      if (finish) begin
         emit     = 1'b1;
         key      = KEY_MOUSE;
         btn_in   = (acc_ff[0] > {4'd0, BTN_MAX}) ? BTN_MAX : acc_ff[0][BTN_W-1:0];
         col_in   = acc_ff[1];
         row_in   = acc_ff[2];
         press_in = (req_rx_byte == CH_PRESS);
      end

      if (emit) mode_in = MODE_IDLE;

      // slot frees on drain, refills on an item that yields a key
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (req_fire && emit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         first_ff     <= '0;
         for (int k = 0; k < NUM_ACC; k++) acc_ff[k] <= '0;
         idx_ff       <= '0;
         btn_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         press_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            mode_ff  <= mode_in;
            first_ff <= first_in;
            acc_ff   <= acc_in;
            idx_ff   <= idx_in;
            btn_ff   <= btn_in;
            col_ff   <= col_in;
            row_ff   <= row_in;
            press_ff <= press_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && emit) key_ff <= key;
   end

   // mouse report only changes on an accepted item, and none is accepted
   // while a result waits, so the stored report doubles as result payload
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_key_code          = key_ff;
   assign rsp_mouse_button_out  = btn_ff;
   assign rsp_mouse_column_out  = col_ff;
   assign rsp_mouse_row_out     = row_ff;
   assign rsp_mouse_pressed_out = press_ff;

endmodule
`default_nettype wire
